// ===== rtl/seud_pkg.sv =====
`timescale 1ns / 1ps
// seud_pkg: shared types and constants for the string unescape / UTF-8 decoder.
// No dependencies.
package seud_pkg;

    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ESC_ERR = 2'd1;
    localparam logic [1:0] STATUS_HEX_ERR = 2'd2;

    typedef enum logic [1:0] {
        MODE_COPY = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_SKIP = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    // Results produced by one input item, in order from slot 0.
    typedef struct packed {
        logic [1:0]                   count;
        t_out_item [MAX_RES-1:0]      items;
    } t_res_group;

endpackage

// ===== rtl/string_escape_utf8_decoder.sv =====
`timescale 1ns / 1ps
// string_escape_utf8_decoder: top level, decoder plus result buffer.
// Depends on seud_pkg, seud_decode, seud_fifo.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one string byte
//   per item with its is_last flag. Output channel (o_out_valid / i_out_ready /
//   o_out_data) gives one result item per cycle while results wait and the
//   receiver is ready: a decoded byte, an error marker, or the end marker
//   after a discarded string tail. Each input item is decoded in the cycle it
//   is accepted; its results are written to a 4-entry result buffer and reach
//   the output in order, behind any results already waiting there.
//   Throughput: one input item per cycle while each item yields at most one
//   result and i_out_ready stays high. A \u escape that expands to 2 or 3
//   UTF-8 bytes drains at one result per cycle through the buffer port, so
//   input pauses while they drain. o_in_ready is high whenever the buffer has
//   room for 3 results. Receiver stall: results wait in the buffer; once fewer
//   than 3 slots are free, o_in_ready drops until the receiver takes items again.
//   Reset (i_rst_n low, synchronous): decoder returns to copy mode, the
//   buffer is emptied, and no result is pending.
module string_escape_utf8_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  seud_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output seud_pkg::t_out_item o_out_data
);
    import seud_pkg::*;

    t_res_group w_res;
    logic       w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    seud_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_res    (w_res)
    );

    seud_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_res),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

// ===== rtl/seud_decode.sv =====
`timescale 1ns / 1ps
// seud_decode: escape / \u state machine; maps one item to up to three results.
// Depends on seud_pkg.
module seud_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  seud_pkg::t_in_item   i_item,
    output seud_pkg::t_res_group o_res
);
    import seud_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;

    logic        w_hex_ok;
    logic [3:0]  w_digit;
    logic [15:0] w_cp;
    logic        w_simple_ok;
    logic [7:0]  w_simple_byte;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic t_out_item mk_item(input logic [7:0] b, input logic v,
                                          input logic [1:0] st);
        t_out_item it;
        it            = '0;
        it.out_byte   = b;
        it.byte_valid = v;
        it.status     = st;
        return it;
    endfunction

    assign {w_hex_ok, w_digit} = hex_val(i_item.in_byte);
    assign w_cp = {r_acc[11:0], w_digit};

    always_comb begin
        w_simple_ok   = 1'b1;
        w_simple_byte = i_item.in_byte;
        unique case (i_item.in_byte) inside
            CH_BSLASH, CH_QUOTE, CH_SLASH: w_simple_byte = i_item.in_byte;
            CH_B:    w_simple_byte = 8'h08;
            CH_F:    w_simple_byte = 8'h0C;
            CH_N:    w_simple_byte = 8'h0A;
            CH_R:    w_simple_byte = 8'h0D;
            CH_T:    w_simple_byte = 8'h09;
            default: w_simple_ok   = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        unique case (r_mode)
            MODE_COPY: begin
                if (i_item.in_byte == CH_BSLASH) n_mode = MODE_ESC;
            end
            MODE_ESC: begin
                if (w_simple_ok) begin
                    n_mode = MODE_COPY;
                end else if (i_item.in_byte == CH_U) begin
                    n_mode = MODE_HEX;
                    n_cnt  = '0;
                    n_acc  = '0;
                end else begin
                    n_mode = MODE_SKIP;
                end
            end
            MODE_HEX: begin
                if (!w_hex_ok) begin
                    n_mode = MODE_SKIP;
                end else if (r_cnt == 2'd3) begin
                    n_mode = MODE_COPY;
                    n_cnt  = '0;
                    n_acc  = '0;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_acc = w_cp;
                end
            end
            MODE_SKIP: n_mode = MODE_SKIP;
            default:   n_mode = MODE_COPY;
        endcase
        if (i_item.is_last) begin
            n_mode = MODE_COPY;
            n_cnt  = '0;
            n_acc  = '0;
        end
    end

    // Outputs
    always_comb begin
        o_res = '0;
        unique case (r_mode)
            MODE_COPY: begin
                if (i_item.in_byte != CH_BSLASH) begin
                    o_res.items[0] = mk_item(i_item.in_byte, 1'b1, STATUS_OK);
                    o_res.count    = 2'd1;
                end else if (i_item.is_last) begin
                    o_res.items[0] = mk_item(8'h00, 1'b0, STATUS_ESC_ERR);
                    o_res.count    = 2'd1;
                end
            end
            MODE_ESC: begin
                if (w_simple_ok) begin
                    o_res.items[0] = mk_item(w_simple_byte, 1'b1, STATUS_OK);
                    o_res.count    = 2'd1;
                end else if (i_item.in_byte != CH_U || i_item.is_last) begin
                    o_res.items[0] = mk_item(8'h00, 1'b0, STATUS_ESC_ERR);
                    o_res.count    = 2'd1;
                end
            end
            MODE_HEX: begin
                if (!w_hex_ok) begin
                    o_res.items[0] = mk_item(8'h00, 1'b0, STATUS_HEX_ERR);
                    o_res.count    = 2'd1;
                end else if (r_cnt == 2'd3) begin
                    if (w_cp <= 16'h007F) begin
                        o_res.items[0] = mk_item(w_cp[7:0], 1'b1, STATUS_OK);
                        o_res.count    = 2'd1;
                    end else if (w_cp <= 16'h07FF) begin
                        o_res.items[0] = mk_item(8'hC0 | {3'b0, w_cp[10:6]}, 1'b1,
                                                 STATUS_OK);
                        o_res.items[1] = mk_item(8'h80 | {2'b0, w_cp[5:0]}, 1'b1,
                                                 STATUS_OK);
                        o_res.count    = 2'd2;
                    end else begin
                        o_res.items[0] = mk_item(8'hE0 | {4'b0, w_cp[15:12]}, 1'b1,
                                                 STATUS_OK);
                        o_res.items[1] = mk_item(8'h80 | {2'b0, w_cp[11:6]}, 1'b1,
                                                 STATUS_OK);
                        o_res.items[2] = mk_item(8'h80 | {2'b0, w_cp[5:0]}, 1'b1,
                                                 STATUS_OK);
                        o_res.count    = 2'd3;
                    end
                end else if (i_item.is_last) begin
                    o_res.items[0] = mk_item(8'h00, 1'b0, STATUS_ESC_ERR);
                    o_res.count    = 2'd1;
                end
            end
            MODE_SKIP: begin
                if (i_item.is_last) begin
                    o_res.items[0] = mk_item(8'h00, 1'b0, STATUS_OK);
                    o_res.count    = 2'd1;
                end
            end
            default: o_res.count = 2'd0;
        endcase
        // tag the final result of this item
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) + 2'd1 == o_res.count) begin
                o_res.items[i].run_last   = 1'b1;
                o_res.items[i].string_end = i_item.is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COPY;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== rtl/seud_fifo.sv =====
`timescale 1ns / 1ps
// seud_fifo: buffer taking up to 3 results per cycle, giving one if ready.
// Depends on seud_pkg.
module seud_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  seud_pkg::t_res_group i_res,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output seud_pkg::t_out_item  o_item
);
    import seud_pkg::*;

    t_out_item        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       w_push_n;
    logic             w_pop;

    assign w_push_n = i_push ? i_res.count : 2'd0;
    assign w_pop    = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= CNT_W'(FIFO_DEPTH - MAX_RES));

    assign n_wr_ptr = r_wr_ptr + PTR_W'(w_push_n);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
    assign n_count  = r_count + CNT_W'(w_push_n) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < w_push_n) begin
                r_mem[r_wr_ptr + PTR_W'(i)] <= i_res.items[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for string_escape_utf8_decoder (escape and \u to UTF-8 decode).
// Depends on seud_pkg and the decoder RTL; predicts every result item and checks it in order.
module tb_top;
    import seud_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam int          RAND_ITEMS = 150;
    localparam logic [7:0]  CH_BSL     = 8'h5c;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  ESC_LETTERS [8] = '{8'h5c, 8'h22, 8'h2f, 8'h62,
                                               8'h66, 8'h6e, 8'h72, 8'h74};

    typedef struct {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_vec_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_mode       dec_mode  = MODE_COPY;
    logic [1:0]  hex_count = '0;
    logic [15:0] cp_acc    = '0;

    t_out_item step_res[$];
    t_out_item decoded_q[$];
    t_vec_row  vec_tbl[$];
    t_out_item got_res;
    t_out_item want_res;
    int        err_cnt    = 0;
    int        res_seen   = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    logic      steady     = 1'b0;

    string_escape_utf8_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_item mk_res(logic [7:0] b, logic v, logic [1:0] st,
                                         logic rl = 1'b0, logic se = 1'b0);
        t_out_item r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.status     = st;
        r.run_last   = rl;
        r.string_end = se;
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    // {known, mapped byte}
    function automatic logic [8:0] esc_map(logic [7:0] c);
        case (c)
            8'h5c: return {1'b1, 8'h5c};
            8'h22: return {1'b1, 8'h22};
            8'h2f: return {1'b1, 8'h2f};
            8'h62: return {1'b1, 8'h08};
            8'h66: return {1'b1, 8'h0c};
            8'h6e: return {1'b1, 8'h0a};
            8'h72: return {1'b1, 8'h0d};
            8'h74: return {1'b1, 8'h09};
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_vec(logic [7:0] b, logic l, logic typed = 1'b0,
                                    t_out_item want = '0);
        t_vec_row r;
        r.item.in_byte = b;
        r.item.is_last = l;
        r.typed        = typed;
        r.want         = want;
        vec_tbl.push_back(r);
    endfunction

    task automatic report_err(string msg);
        err_cnt++;
        if (err_cnt <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_err($sformatf("result %0d %s got %0h want %0h", res_seen, name, got, want));
    endtask

    task automatic escape_fault(logic [1:0] st);
        step_res.push_back(mk_res(8'h00, 1'b0, st));
        dec_mode = MODE_SKIP;
    endtask

    // Advances the decoder state by one item and fills step_res with its results.
    task automatic decode_item(t_in_item it);
        logic [7:0]  c;
        logic [4:0]  hv;
        logic [8:0]  em;
        logic [15:0] cp;
        c = it.in_byte;
        step_res.delete();
        case (dec_mode)
            MODE_COPY: begin
                if (c == CH_BSL) begin
                    dec_mode = MODE_ESC;
                    if (it.is_last) escape_fault(STATUS_ESC_ERR);
                end else begin
                    step_res.push_back(mk_res(c, 1'b1, STATUS_OK));
                end
            end
            MODE_ESC: begin
                em = esc_map(c);
                if (em[8]) begin
                    step_res.push_back(mk_res(em[7:0], 1'b1, STATUS_OK));
                    dec_mode = MODE_COPY;
                end else if (c == CH_U) begin
                    dec_mode  = MODE_HEX;
                    hex_count = '0;
                    cp_acc    = '0;
                    if (it.is_last) escape_fault(STATUS_ESC_ERR);
                end else begin
                    escape_fault(STATUS_ESC_ERR);
                end
            end
            MODE_HEX: begin
                hv = hex_val(c);
                if (!hv[4]) begin
                    escape_fault(STATUS_HEX_ERR);
                end else begin
                    cp_acc = {cp_acc[11:0], hv[3:0]};
                    if (hex_count == 2'd3) begin
                        cp = cp_acc;
                        if (cp <= 16'h007f) begin
                            step_res.push_back(mk_res(cp[7:0], 1'b1, STATUS_OK));
                        end else if (cp <= 16'h07ff) begin
                            step_res.push_back(mk_res({3'b110, cp[10:6]}, 1'b1, STATUS_OK));
                            step_res.push_back(mk_res({2'b10, cp[5:0]}, 1'b1, STATUS_OK));
                        end else begin
                            step_res.push_back(mk_res({4'b1110, cp[15:12]}, 1'b1, STATUS_OK));
                            step_res.push_back(mk_res({2'b10, cp[11:6]}, 1'b1, STATUS_OK));
                            step_res.push_back(mk_res({2'b10, cp[5:0]}, 1'b1, STATUS_OK));
                        end
                        dec_mode  = MODE_COPY;
                        hex_count = '0;
                        cp_acc    = '0;
                    end else begin
                        hex_count = hex_count + 2'd1;
                        if (it.is_last) escape_fault(STATUS_ESC_ERR);
                    end
                end
            end
            default: begin
                if (it.is_last) step_res.push_back(mk_res(8'h00, 1'b0, STATUS_OK));
            end
        endcase
        if (step_res.size() > 0) begin
            step_res[step_res.size()-1].run_last   = 1'b1;
            step_res[step_res.size()-1].string_end = it.is_last;
        end
        if (it.is_last) begin
            dec_mode  = MODE_COPY;
            hex_count = '0;
            cp_acc    = '0;
        end
    endtask

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(t_in_item it, logic typed = 1'b0, t_out_item want = '0);
        if (!steady && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        decode_item(it);
        if (typed) decoded_q.push_back(want);
        else foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    endtask

    task automatic send_random_string();
        logic [7:0]  sbuf[$];
        logic [7:0]  b;
        logic [8:0]  em;
        logic [4:0]  hv;
        logic [15:0] cp;
        t_in_item    it;
        int          k;
        int          cut;
        repeat ($urandom_range(1, 6)) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 39) == 0) b = 8'h00;
                else if (b == CH_BSL) b = 8'h7e;
                sbuf.push_back(b);
            end else if (k < 65) begin
                sbuf.push_back(CH_BSL);
                sbuf.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
            end else if (k < 88) begin
                case ($urandom_range(0, 2))
                    0:       cp = 16'($urandom_range(0, 16'h007f));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07ff));
                    default: cp = 16'($urandom_range(16'h0800, 16'hffff));
                endcase
                sbuf.push_back(CH_BSL);
                sbuf.push_back(CH_U);
                for (int i = 3; i >= 0; i--)
                    sbuf.push_back(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
            end else begin
                sbuf.push_back(CH_BSL);
                case ($urandom_range(0, 2))
                    0: begin
                        do begin
                            b  = 8'($urandom_range(0, 255));
                            em = esc_map(b);
                        end while (em[8] || b == CH_U);
                        sbuf.push_back(b);
                    end
                    1: begin
                        sbuf.push_back(CH_U);
                        repeat ($urandom_range(0, 3))
                            sbuf.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                        do begin
                            b  = 8'($urandom_range(0, 255));
                            hv = hex_val(b);
                        end while (hv[4]);
                        sbuf.push_back(b);
                    end
                    default: ;
                endcase
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, sbuf.size());
            while (sbuf.size() > cut) void'(sbuf.pop_back());
        end
        foreach (sbuf[i]) begin
            it.in_byte = sbuf[i];
            it.is_last = (i == sbuf.size() - 1);
            send_item(it);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = o_out_data;
            if (decoded_q.size() == 0) begin
                report_err($sformatf("unexpected result byte %02h status %0d",
                                     got_res.out_byte, got_res.status));
            end else begin
                want_res = decoded_q.pop_front();
                check_field("out_byte", got_res.out_byte, want_res.out_byte);
                check_field("byte_valid", got_res.byte_valid, want_res.byte_valid);
                check_field("status", got_res.status, want_res.status);
                check_field("run_last", got_res.run_last, want_res.run_last);
                check_field("string_end", got_res.string_end, want_res.string_end);
            end
            res_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic drained;
        drained = 1'b0;

        add_vec(8'h41, 1'b0, 1'b1, mk_res(8'h41, 1'b1, STATUS_OK, 1'b1, 1'b0));
        add_vec(8'hff, 1'b1, 1'b1, mk_res(8'hff, 1'b1, STATUS_OK, 1'b1, 1'b1));
        // unknown escape, then discard up to end marker
        add_vec(CH_BSL, 1'b0);
        add_vec(8'h71, 1'b0, 1'b1, mk_res(8'h00, 1'b0, STATUS_ESC_ERR, 1'b1, 1'b0));
        add_vec(8'h78, 1'b1, 1'b1, mk_res(8'h00, 1'b0, STATUS_OK, 1'b1, 1'b1));
        // \u0000 gives a valid zero byte
        add_vec(CH_BSL, 1'b0);
        add_vec(CH_U, 1'b0);
        add_vec(8'h30, 1'b0);
        add_vec(8'h30, 1'b0);
        add_vec(8'h30, 1'b0);
        add_vec(8'h30, 1'b0, 1'b1, mk_res(8'h00, 1'b1, STATUS_OK, 1'b1, 1'b0));
        // \uFFFF as last bytes: three-byte form
        add_vec(CH_BSL, 1'b0);
        add_vec(CH_U, 1'b0);
        add_vec(8'h46, 1'b0);
        add_vec(8'h66, 1'b0);
        add_vec(8'h46, 1'b0);
        add_vec(8'h66, 1'b1);
        // bad hex digit
        add_vec(CH_BSL, 1'b0);
        add_vec(CH_U, 1'b0);
        add_vec(8'h31, 1'b0);
        add_vec(8'h67, 1'b0, 1'b1, mk_res(8'h00, 1'b0, STATUS_HEX_ERR, 1'b1, 1'b0));
        add_vec(8'h7a, 1'b1, 1'b1, mk_res(8'h00, 1'b0, STATUS_OK, 1'b1, 1'b1));
        // string ends inside \u, then on a bare backslash
        add_vec(CH_BSL, 1'b0);
        add_vec(CH_U, 1'b0);
        add_vec(8'h41, 1'b1, 1'b1, mk_res(8'h00, 1'b0, STATUS_ESC_ERR, 1'b1, 1'b1));
        add_vec(CH_BSL, 1'b1, 1'b1, mk_res(8'h00, 1'b0, STATUS_ESC_ERR, 1'b1, 1'b1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vec_tbl[i]) send_item(vec_tbl[i].item, vec_tbl[i].typed, vec_tbl[i].want);

        while (items_sent < RAND_ITEMS) begin
            steady = (items_sent >= 60 && items_sent < 100);
            if (!drained && items_sent >= 110) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (decoded_q.size() != 0);
                drained = 1'b1;
            end
            send_random_string();
        end
        steady = 1'b0;

        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
